>>> rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types, string tables and helper functions for the HTML text
// extractor: payload structs, parser mode codes, controller command/status.
// ----------------------------------------------------------------------------
package hte_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       end_of_document;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_done;
   } rsp_type;

   typedef enum logic [12:0] {
      M_TEXT      = 13'b0000000000001,
      M_LT        = 13'b0000000000010,
      M_PCOM      = 13'b0000000000100,
      M_PS        = 13'b0000000001000,
      M_PSCRIPT   = 13'b0000000010000,
      M_PSTYLE    = 13'b0000000100000,
      M_TAG       = 13'b0000001000000,
      M_COMMENT   = 13'b0000010000000,
      M_SCRIPT    = 13'b0000100000000,
      M_SCRIPT_GT = 13'b0001000000000,
      M_STYLE     = 13'b0010000000000,
      M_STYLE_GT  = 13'b0100000000000,
      M_ENT       = 13'b1000000000000
   } mode_type;

   typedef struct packed {
      logic load_item;
      logic parse;
      logic drain;
      logic flush_start;
      logic flush_load;
      logic flush_done;
      logic release_out;
      logic doc_reset;
   } hte_cmd_type;

   typedef struct packed {
      logic emit_busy;
      logic push_ok;
      logic out_free;
      logic flush_more;
      logic flush_req;
      logic item_end;
      logic ent_mode;
   } hte_status_type;

   localparam int NumEnt   = 7;
   localparam int NumBlock = 34;
   localparam int EntDepth = 6;
   localparam int NameMax  = 10;

   localparam logic [7:0] CH_NL  = 8'h0a;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR  = 8'h0d;

   // strings are right-justified in an 80-bit word
   localparam logic [79:0] ENT_NAME [NumEnt] = '{
      80'("&amp;"), 80'("&lt;"), 80'("&gt;"), 80'("&quot;"),
      80'("&nbsp;"), 80'("&apos;"), 80'("&#39;")
   };
   localparam logic [3:0] ENT_LEN [NumEnt] = '{
      4'd5, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd5
   };
   localparam logic [7:0] ENT_REP [NumEnt] = '{
      8'h26, 8'h3c, 8'h3e, 8'h22, 8'h20, 8'h27, 8'h27
   };

   localparam logic [79:0] BLOCK_TAG [NumBlock] = '{
      80'("p"), 80'("div"), 80'("br"), 80'("hr"), 80'("li"), 80'("ul"), 80'("ol"),
      80'("tr"), 80'("td"), 80'("th"), 80'("table"), 80'("thead"), 80'("tbody"),
      80'("h1"), 80'("h2"), 80'("h3"), 80'("h4"), 80'("h5"), 80'("h6"),
      80'("blockquote"), 80'("pre"), 80'("section"), 80'("article"),
      80'("header"), 80'("footer"), 80'("nav"), 80'("aside"), 80'("main"),
      80'("form"), 80'("figure"), 80'("figcaption"), 80'("dl"), 80'("dt"), 80'("dd")
   };
   localparam logic [3:0] BLOCK_LEN [NumBlock] = '{
      4'd1, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
      4'd2, 4'd2, 4'd2, 4'd5, 4'd5, 4'd5,
      4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
      4'd10, 4'd3, 4'd7, 4'd7,
      4'd6, 4'd6, 4'd3, 4'd5, 4'd4,
      4'd4, 4'd6, 4'd10, 4'd2, 4'd2, 4'd2
   };

   localparam logic [79:0] PAT_SCRIPT = 80'("<script");
   localparam logic [3:0]  LEN_SCRIPT = 4'd7;
   localparam logic [79:0] PAT_STYLE  = 80'("<style");
   localparam logic [3:0]  LEN_STYLE  = 4'd6;
   localparam logic [79:0] END_SCRIPT = 80'("</script");
   localparam logic [3:0]  LEN_ESCR   = 4'd8;
   localparam logic [79:0] END_STYLE  = 80'("</style");
   localparam logic [3:0]  LEN_ESTY   = 4'd7;

   function automatic logic [7:0] str_char(logic [79:0] s, logic [3:0] len,
                                           logic [3:0] pos);
      int sh;
      sh = 8 * (int'(len) - 1 - int'(pos));
      if (pos >= len) begin
         return 8'h00;
      end
      return s[sh +: 8];
   endfunction

   function automatic logic [7:0] lower(logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_alnum(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [NumBlock-1:0] mask_upd(logic [NumBlock-1:0] m,
                                                    logic [3:0] pos, logic [7:0] lc);
      logic [NumBlock-1:0] r;
      for (int t = 0; t < NumBlock; t++) begin
         r[t] = m[t] && (str_char(BLOCK_TAG[t], BLOCK_LEN[t], pos) == lc);
      end
      return r;
   endfunction

   function automatic logic is_block(logic [NumBlock-1:0] m, logic [3:0] len,
                                     logic ovf);
      logic hit;
      hit = 1'b0;
      for (int t = 0; t < NumBlock; t++) begin
         if (m[t] && BLOCK_LEN[t] == len) begin
            hit = 1'b1;
         end
      end
      return hit && !ovf;
   endfunction

endpackage

>>> rtl/hte_ctrl.sv
// ----------------------------------------------------------------------------
// hte_ctrl
// Sequencer for one input beat: parse, entity replay, output drain and
// end-of-step release.
// ----------------------------------------------------------------------------
module hte_ctrl import hte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  hte_status_type status,
   output hte_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PARSE  = 5'b00010,
      S_FLUSH  = 5'b00100,
      S_POST   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      reparse_ff, reparse_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      reparse_in = reparse_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_PARSE;
            end
         end
         S_PARSE: begin
            cmd.parse = 1'b1;
            if (status.flush_req) begin
               cmd.flush_start = 1'b1;
               reparse_in      = 1'b1;
               state_in        = S_FLUSH;
            end else begin
               state_in = S_POST;
            end
         end
         S_FLUSH: begin
            if (status.emit_busy) begin
               cmd.drain = status.push_ok;
            end else if (status.flush_more) begin
               cmd.flush_load = 1'b1;
            end else begin
               cmd.flush_done = 1'b1;
               // breaking byte goes through the parser again in text mode
               state_in = reparse_ff ? S_PARSE : S_POST;
            end
         end
         S_POST: begin
            if (status.emit_busy) begin
               cmd.drain = status.push_ok;
            end else if (status.item_end && status.ent_mode) begin
               cmd.flush_start = 1'b1;
               reparse_in      = 1'b0;
               state_in        = S_FLUSH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.release_out = 1'b1;
               cmd.doc_reset   = status.item_end;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         reparse_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         reparse_ff <= reparse_in;
      end
   end

endmodule

>>> rtl/hte_datapath.sv
// ----------------------------------------------------------------------------
// hte_datapath
// Parser state, entity buffer, whitespace stage, one-beat hold register and
// output register.
// ----------------------------------------------------------------------------
module hte_datapath import hte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_payload,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rsp_type        rsp_payload,
   input  hte_cmd_type    cmd,
   output hte_status_type status
);

   req_type             item_ff;
   mode_type            mode_ff, mode_in;
   logic [2:0]          pmc_ff, pmc_in;
   logic [3:0]          close_ff, close_in;
   logic [7:0]          ebuf_ff [EntDepth];
   logic [2:0]          elen_ff, elen_in;
   logic [NumEnt-1:0]   cand_ff, cand_in;
   logic [3:0]          nlen_ff, nlen_in;
   logic [NumBlock-1:0] nmask_ff, nmask_in;
   logic                nend_ff, nend_in;
   logic                novf_ff, novf_in;
   logic [2:0]          fi_ff, fi_in;
   logic [1:0]          pnl_ff, pnl_in;
   logic                pb_ff, pb_in;
   logic                lht_ff, lht_in;
   logic [1:0]          em_nl_ff, em_nl_in;
   logic                em_sp_ff, em_sp_in;
   logic                em_ch_ff, em_ch_in;
   logic [7:0]          em_c_ff, em_c_in;
   logic                hold_v_ff, hold_v_in;
   logic [7:0]          hold_b_ff, hold_b_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                ebuf_we;
   logic [2:0]          ebuf_wa;
   logic [7:0]          ebuf_wd;
   logic                s2_load;
   logic [7:0]          s2_char;
   logic                flush_req;
   logic [7:0]          c, lc;
   logic                do_tag, do_add;
   logic [3:0]          k;
   logic [NumEnt-1:0]   cand_new, full;
   logic [7:0]          rep;
   logic                ld;
   logic [7:0]          ch;
   logic                push;
   logic [7:0]          pbyte;
   logic                out_free;

   assign c        = item_ff.in_byte;
   assign lc       = lower(item_ff.in_byte);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // parser
   always_comb begin
      mode_in   = mode_ff;
      pmc_in    = pmc_ff;
      close_in  = close_ff;
      elen_in   = elen_ff;
      cand_in   = cand_ff;
      nlen_in   = nlen_ff;
      nmask_in  = nmask_ff;
      nend_in   = nend_ff;
      novf_in   = novf_ff;
      fi_in     = fi_ff;
      ebuf_we   = 1'b0;
      ebuf_wa   = elen_ff;
      ebuf_wd   = c;
      s2_load   = 1'b0;
      s2_char   = c;
      flush_req = 1'b0;
      do_tag    = 1'b0;
      do_add    = 1'b0;
      k         = 4'd0;
      rep       = 8'h00;
      cand_new  = '0;
      full      = '0;
      if (cmd.parse && item_ff.has_byte) begin
         case (mode_ff)
            M_TEXT: begin
               if (c == "&") begin
                  mode_in = M_ENT;
                  ebuf_we = 1'b1;
                  ebuf_wa = 3'd0;
                  elen_in = 3'd1;
                  cand_in = '1;
               end else if (c == "<") begin
                  mode_in  = M_LT;
                  pmc_in   = 3'd1;
                  nlen_in  = 4'd0;
                  nmask_in = '1;
                  nend_in  = 1'b0;
                  novf_in  = 1'b0;
               end else begin
                  s2_load = 1'b1;
               end
            end
            M_LT: begin
               if (c == "!") begin
                  mode_in = M_PCOM;
                  pmc_in  = 3'd2;
               end else if (lc == "s") begin
                  do_add  = 1'b1;
                  mode_in = M_PS;
                  pmc_in  = 3'd2;
               end else begin
                  mode_in = M_TAG;
                  nend_in = 1'b0;
                  pmc_in  = 3'd0;
                  do_tag  = (c != "/");
               end
            end
            M_PCOM: begin
               if (c == "-") begin
                  if (pmc_ff >= 3'd3) begin
                     mode_in  = M_COMMENT;
                     close_in = 4'd0;
                     pmc_in   = 3'd0;
                  end else begin
                     pmc_in = 3'd3;
                  end
               end else begin
                  // "<!" starts a tag whose name is already over
                  mode_in = M_TAG;
                  nend_in = 1'b1;
                  pmc_in  = 3'd0;
                  do_tag  = 1'b1;
               end
            end
            M_PS: begin
               if (lc == "c") begin
                  do_add  = 1'b1;
                  mode_in = M_PSCRIPT;
                  pmc_in  = 3'd3;
               end else if (lc == "t") begin
                  do_add  = 1'b1;
                  mode_in = M_PSTYLE;
                  pmc_in  = 3'd3;
               end else begin
                  mode_in = M_TAG;
                  nend_in = 1'b0;
                  pmc_in  = 3'd0;
                  do_tag  = 1'b1;
               end
            end
            M_PSCRIPT, M_PSTYLE: begin
               if (mode_ff == M_PSCRIPT) begin
                  k = {1'b0, pmc_ff};
                  if (lc == str_char(PAT_SCRIPT, LEN_SCRIPT, k)) begin
                     if (k + 4'd1 == LEN_SCRIPT) begin
                        mode_in  = M_SCRIPT;
                        close_in = 4'd0;
                        pmc_in   = 3'd0;
                        nlen_in  = 4'd0;
                        nmask_in = '1;
                     end else begin
                        do_add = 1'b1;
                        pmc_in = pmc_ff + 3'd1;
                     end
                  end else begin
                     mode_in = M_TAG;
                     nend_in = 1'b0;
                     pmc_in  = 3'd0;
                     do_tag  = 1'b1;
                  end
               end else begin
                  k = {1'b0, pmc_ff};
                  if (lc == str_char(PAT_STYLE, LEN_STYLE, k)) begin
                     if (k + 4'd1 == LEN_STYLE) begin
                        mode_in  = M_STYLE;
                        close_in = 4'd0;
                        pmc_in   = 3'd0;
                        nlen_in  = 4'd0;
                        nmask_in = '1;
                     end else begin
                        do_add = 1'b1;
                        pmc_in = pmc_ff + 3'd1;
                     end
                  end else begin
                     mode_in = M_TAG;
                     nend_in = 1'b0;
                     pmc_in  = 3'd0;
                     do_tag  = 1'b1;
                  end
               end
            end
            M_TAG: begin
               do_tag = 1'b1;
            end
            M_COMMENT: begin
               k = (close_ff > 4'd2) ? 4'd0 : close_ff;
               if ((k < 4'd2 && c == "-") || (k == 4'd2 && c == ">")) begin
                  if (k == 4'd2) begin
                     mode_in  = M_TEXT;
                     close_in = 4'd0;
                  end else begin
                     close_in = k + 4'd1;
                  end
               end else if (!(k == 4'd2 && c == "-")) begin
                  close_in = 4'd0;
               end else begin
                  close_in = k;
               end
            end
            M_SCRIPT: begin
               if (close_ff < LEN_ESCR && lc == str_char(END_SCRIPT, LEN_ESCR, close_ff)) begin
                  if (close_ff + 4'd1 == LEN_ESCR) begin
                     mode_in  = M_SCRIPT_GT;
                     close_in = 4'd0;
                  end else begin
                     close_in = close_ff + 4'd1;
                  end
               end else begin
                  close_in = (c == "<") ? 4'd1 : 4'd0;
               end
            end
            M_STYLE: begin
               if (close_ff < LEN_ESTY && lc == str_char(END_STYLE, LEN_ESTY, close_ff)) begin
                  if (close_ff + 4'd1 == LEN_ESTY) begin
                     mode_in  = M_STYLE_GT;
                     close_in = 4'd0;
                  end else begin
                     close_in = close_ff + 4'd1;
                  end
               end else begin
                  close_in = (c == "<") ? 4'd1 : 4'd0;
               end
            end
            M_SCRIPT_GT, M_STYLE_GT: begin
               if (c == ">") begin
                  mode_in  = M_TEXT;
                  close_in = 4'd0;
               end
            end
            M_ENT: begin
               for (int e = NumEnt - 1; e >= 0; e--) begin
                  cand_new[e] = cand_ff[e] && ({1'b0, elen_ff} < ENT_LEN[e]) &&
                                (lc == str_char(ENT_NAME[e], ENT_LEN[e], {1'b0, elen_ff}));
                  full[e]     = cand_new[e] && (ENT_LEN[e] == {1'b0, elen_ff} + 4'd1);
                  if (full[e]) begin
                     rep = ENT_REP[e];
                  end
               end
               if (|full) begin
                  s2_load = 1'b1;
                  s2_char = rep;
                  elen_in = 3'd0;
                  mode_in = M_TEXT;
               end else if (|cand_new) begin
                  ebuf_we = 1'b1;
                  elen_in = elen_ff + 3'd1;
                  cand_in = cand_new;
               end else begin
                  flush_req = 1'b1;
               end
            end
            default: begin
               mode_in = M_TEXT;
            end
         endcase
      end

      if (do_add && nlen_ff < 4'(NameMax)) begin
         nmask_in = mask_upd(nmask_ff, nlen_ff, lc);
         nlen_in  = nlen_ff + 4'd1;
      end

      if (do_tag) begin
         if (c == ">") begin
            if (is_block(nmask_in, nlen_in, novf_in)) begin
               s2_load = 1'b1;
               s2_char = CH_NL;
            end
            mode_in  = M_TEXT;
            nlen_in  = 4'd0;
            nmask_in = '1;
            nend_in  = 1'b0;
            novf_in  = 1'b0;
         end else if (!nend_in && is_alnum(c)) begin
            if (nlen_in < 4'(NameMax)) begin
               nmask_in = mask_upd(nmask_in, nlen_in, lc);
               nlen_in  = nlen_in + 4'd1;
            end else begin
               novf_in = 1'b1;
            end
         end else begin
            nend_in = 1'b1;
         end
      end

      if (cmd.flush_start) begin
         fi_in = 3'd0;
      end
      if (cmd.flush_load) begin
         fi_in = fi_ff + 3'd1;
      end
      if (cmd.flush_done) begin
         elen_in = 3'd0;
         mode_in = M_TEXT;
      end
      if (cmd.doc_reset) begin
         mode_in  = M_TEXT;
         pmc_in   = 3'd0;
         close_in = 4'd0;
         elen_in  = 3'd0;
         nlen_in  = 4'd0;
         nmask_in = '1;
         nend_in  = 1'b0;
         novf_in  = 1'b0;
      end
   end

   // whitespace stage, hold register and output register
   always_comb begin
      pnl_in       = pnl_ff;
      pb_in        = pb_ff;
      lht_in       = lht_ff;
      em_nl_in     = em_nl_ff;
      em_sp_in     = em_sp_ff;
      em_ch_in     = em_ch_ff;
      em_c_in      = em_c_ff;
      hold_v_in    = hold_v_ff;
      hold_b_in    = hold_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      push         = 1'b0;
      pbyte        = em_c_ff;
      ld           = s2_load || cmd.flush_load;
      ch           = cmd.flush_load ? ebuf_ff[fi_ff] : s2_char;

      if (ld) begin
         if (ch == CH_NL) begin
            pnl_in = (pnl_ff == 2'd2) ? 2'd2 : pnl_ff + 2'd1;
            pb_in  = 1'b0;
         end else if (ch == CH_SP || ch == CH_TAB || ch == CH_CR) begin
            pb_in = 1'b1;
         end else begin
            em_nl_in = (pnl_ff != 2'd0 && lht_ff) ? pnl_ff : 2'd0;
            em_sp_in = pb_ff && pnl_ff == 2'd0 && lht_ff;
            em_ch_in = 1'b1;
            em_c_in  = ch;
            pnl_in   = 2'd0;
            pb_in    = 1'b0;
            lht_in   = 1'b1;
         end
      end

      if (cmd.drain) begin
         push = 1'b1;
         if (em_nl_ff != 2'd0) begin
            pbyte    = CH_NL;
            em_nl_in = em_nl_ff - 2'd1;
         end else if (em_sp_ff) begin
            pbyte    = CH_SP;
            em_sp_in = 1'b0;
         end else begin
            pbyte    = em_c_ff;
            em_ch_in = 1'b0;
         end
      end

      // the newest byte waits in the hold register until we know if it is last
      if (push) begin
         if (hold_v_ff) begin
            rsp_in       = '{out_byte: hold_b_ff, byte_valid: 1'b1, run_last: 1'b0,
                             text_done: 1'b0};
            rsp_valid_in = 1'b1;
         end
         hold_b_in = pbyte;
         hold_v_in = 1'b1;
      end

      if (cmd.release_out) begin
         if (hold_v_ff) begin
            rsp_in       = '{out_byte: hold_b_ff, byte_valid: 1'b1, run_last: 1'b1,
                             text_done: item_ff.end_of_document};
            rsp_valid_in = 1'b1;
            hold_v_in    = 1'b0;
         end else if (item_ff.end_of_document) begin
            rsp_in       = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                             text_done: 1'b1};
            rsp_valid_in = 1'b1;
         end
      end

      if (cmd.doc_reset) begin
         pnl_in = 2'd0;
         pb_in  = 1'b0;
         lht_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      if (ebuf_we) begin
         ebuf_ff[ebuf_wa] <= ebuf_wd;
      end
      em_c_ff   <= em_c_in;
      hold_b_ff <= hold_b_in;
      rsp_ff    <= rsp_in;
      fi_ff     <= fi_in;
      cand_ff   <= cand_in;
      nmask_ff  <= nmask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_TEXT;
         pmc_ff       <= 3'd0;
         close_ff     <= 4'd0;
         elen_ff      <= 3'd0;
         nlen_ff      <= 4'd0;
         nend_ff      <= 1'b0;
         novf_ff      <= 1'b0;
         pnl_ff       <= 2'd0;
         pb_ff        <= 1'b0;
         lht_ff       <= 1'b0;
         em_nl_ff     <= 2'd0;
         em_sp_ff     <= 1'b0;
         em_ch_ff     <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pmc_ff       <= pmc_in;
         close_ff     <= close_in;
         elen_ff      <= elen_in;
         nlen_ff      <= nlen_in;
         nend_ff      <= nend_in;
         novf_ff      <= novf_in;
         pnl_ff       <= pnl_in;
         pb_ff        <= pb_in;
         lht_ff       <= lht_in;
         em_nl_ff     <= em_nl_in;
         em_sp_ff     <= em_sp_in;
         em_ch_ff     <= em_ch_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.emit_busy  = (em_nl_ff != 2'd0) || em_sp_ff || em_ch_ff;
   assign status.push_ok    = !hold_v_ff || out_free;
   assign status.out_free   = out_free;
   assign status.flush_more = (fi_ff < elen_ff);
   assign status.flush_req  = flush_req;
   assign status.item_end   = item_ff.end_of_document;
   assign status.ent_mode   = (mode_ff == M_ENT);

endmodule

>>> rtl/html_text_extractor.sv
// ----------------------------------------------------------------------------
// html_text_extractor
// Streaming HTML to plain text: strips tags, comments, script and style,
// decodes the entities in its table and normalizes whitespace.
// ----------------------------------------------------------------------------
//   channel   dir  handshake             beat
//   req_      in   req_valid/req_stall   one document byte (or end-only)
//   rsp_      out  rsp_valid/rsp_stall   one text byte, or end marker
//
// One input beat at a time: the beat is accepted and parsed, its output bytes
// are drained while the hold stage can take them, and then the last byte is
// released. A failed entity replays its buffered bytes, then parses the
// breaking byte again in text mode.
// Output bytes leave through a one-deep hold stage and an output register;
// rsp_stall pauses the drain. Reset is synchronous; a document end also
// returns all parser state to its reset values.
// ----------------------------------------------------------------------------
module html_text_extractor import hte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   hte_cmd_type    cmd;
   hte_status_type status;

   hte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hte_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
